// ===== hw/rtl/spq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Number of slots in the chain
    localparam int Depth  = 16;
    // Width of the occupancy counter, able to hold Depth itself
    localparam int CountW = $clog2(Depth + 1);
    localparam int DataW  = 32;
    localparam int PrioW  = 32;
    localparam int OutCountW = 5;

    // Request operation codes
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2,
        OP_PEEK   = 2'd3
    } op_t;

    // Control broadcast from the top level to every cell
    typedef struct packed {
        logic write_en;     // append or insert that fits
        logic by_priority;  // insert: claim slot by priority compare
        logic pop_en;       // shift every entry one place towards the head
    } cell_ctrl_t;

endpackage : spq_pkg
`default_nettype wire

// ===== hw/rtl/spq_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the queue chain: holds an entry, decides whether to keep it,
// take the new entry, or take a neighbour's entry.
// ----------------------------------------------------------------------------
module spq_cell (
    input  wire                                   clk,
    input  wire spq_pkg::cell_ctrl_t              ctrl,
    input  wire                                   slot_valid,
    input  wire signed [spq_pkg::DataW-1:0]       new_data,
    input  wire signed [spq_pkg::PrioW-1:0]       new_prio,
    input  wire signed [spq_pkg::DataW-1:0]       left_data,
    input  wire signed [spq_pkg::PrioW-1:0]       left_prio,
    input  wire signed [spq_pkg::DataW-1:0]       right_data,
    input  wire signed [spq_pkg::PrioW-1:0]       right_prio,
    input  wire                                   chain_in,
    output logic                                  chain_out,
    output logic signed [spq_pkg::DataW-1:0]      data_q,
    output logic signed [spq_pkg::PrioW-1:0]      prio_q
);
    import spq_pkg::*;

    logic signed [DataW-1:0] data_reg, data_next;
    logic signed [PrioW-1:0] prio_reg, prio_next;
    logic                    claim;

    // Slot claim: first free slot on append; on insert also an occupied slot
    // holding a strictly lower priority
    always_comb
    begin
        if (ctrl.by_priority)
            claim = !slot_valid || (prio_reg < new_prio);
        else
            claim = !slot_valid;
    end

    // Claim ripples down the chain: everything after the claimed slot shifts
    assign chain_out = chain_in || claim;

    always_comb
    begin
        data_next = data_reg;
        prio_next = prio_reg;
        if (ctrl.pop_en)
        begin
            data_next = right_data;
            prio_next = right_prio;
        end
        else if (ctrl.write_en)
        begin
            if (chain_in)
            begin
                data_next = left_data;
                prio_next = left_prio;
            end
            else if (claim)
            begin
                data_next = new_data;
                prio_next = new_prio;
            end
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

    assign data_q = data_reg;
    assign prio_q = prio_reg;

endmodule : spq_cell
`default_nettype wire

// ===== hw/rtl/stable_priority_queue.sv =====
`default_nettype none
// A request accepted at a clock edge has its result strobed in the next cycle.
// Throughput: one request per cycle; every cell updates in parallel and the
// insert position ripples once through the cell chain in that cycle.
// busy is never raised. Reset clears the occupancy and the result strobe;
// slot contents are not cleared and are never shown while unoccupied.
// ----------------------------------------------------------------------------
// stable_priority_queue
// Ordered store built as a chain of slot cells; append, stable priority
// insert, pop and peek, each returning the head and occupancy.
// ----------------------------------------------------------------------------
module stable_priority_queue (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    output logic               busy,
    input  wire  [1:0]         op,
    input  wire  signed [31:0] item_data,
    input  wire  signed [31:0] item_priority,
    output logic               done,
    output logic signed [31:0] head_data,
    output logic signed [31:0] head_priority,
    output logic               is_empty,
    output logic [4:0]         entry_count,
    output logic               rejected
);
    import spq_pkg::*;

    logic [CountW-1:0]       occ_reg, occ_next;
    logic                    done_reg;
    logic                    rejected_reg, rejected_next;
    logic                    accept;
    logic                    full;
    logic                    is_write;
    cell_ctrl_t              ctrl;

    logic signed [DataW-1:0] cell_data [Depth];
    logic signed [PrioW-1:0] cell_prio [Depth];
    logic                    chain    [Depth+1];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (occ_reg == CountW'(Depth));

    // Decode request into the cell control word
    always_comb
    begin
        is_write         = 1'b0;
        ctrl.write_en    = 1'b0;
        ctrl.by_priority = 1'b0;
        ctrl.pop_en      = 1'b0;
        case (op_t'(op))
            OP_APPEND: is_write = 1'b1;
            OP_INSERT:
            begin
                is_write         = 1'b1;
                ctrl.by_priority = 1'b1;
            end
            OP_POP:  ctrl.pop_en = accept && (occ_reg != '0);
            OP_PEEK: ;
            default: ;
        endcase
        ctrl.write_en = accept && is_write && !full;
    end

    // Occupancy and reject flag
    always_comb
    begin
        occ_next      = occ_reg;
        rejected_next = rejected_reg;
        if (accept)
            rejected_next = is_write && full;
        if (ctrl.write_en)
            occ_next = occ_reg + 1'b1;
        else if (ctrl.pop_en)
            occ_next = occ_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg      <= '0;
            done_reg     <= 1'b0;
            rejected_reg <= 1'b0;
        end
        else
        begin
            occ_reg      <= occ_next;
            done_reg     <= accept;
            rejected_reg <= rejected_next;
        end
    end

    // Chain of slot cells, head at index 0
    assign chain[0] = 1'b0;

    for (genvar i = 0; i < Depth; i++)
    begin : g_cell
        logic signed [DataW-1:0] left_d, right_d;
        logic signed [PrioW-1:0] left_p, right_p;
        logic                    valid;

        assign valid = (occ_reg > CountW'(i));

        if (i == 0)
        begin : g_head
            assign left_d = '0;
            assign left_p = '0;
        end
        else
        begin : g_mid
            assign left_d = cell_data[i-1];
            assign left_p = cell_prio[i-1];
        end

        if (i == Depth - 1)
        begin : g_tail
            assign right_d = '0;
            assign right_p = '0;
        end
        else
        begin : g_nxt
            assign right_d = cell_data[i+1];
            assign right_p = cell_prio[i+1];
        end

        spq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .slot_valid (valid),
            .new_data   (item_data),
            .new_prio   (item_priority),
            .left_data  (left_d),
            .left_prio  (left_p),
            .right_data (right_d),
            .right_prio (right_p),
            .chain_in   (chain[i]),
            .chain_out  (chain[i+1]),
            .data_q     (cell_data[i]),
            .prio_q     (cell_prio[i])
        );
    end

    // Result ports, valid during the strobe cycle
    assign done          = done_reg;
    assign is_empty      = (occ_reg == '0);
    assign head_data     = is_empty ? '0 : cell_data[0];
    assign head_priority = is_empty ? '0 : cell_prio[0];
    assign entry_count   = OutCountW'(occ_reg);
    assign rejected      = rejected_reg;

endmodule : stable_priority_queue
`default_nettype wire
